// ===== rtl/core/sfcp_pkg.sv =====
`default_nettype none
package sfcp_pkg;

  localparam int LINE_MAX = 64;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int CNT_W    = 7;
  localparam int PING_LEN = 4;
  localparam int TEXT_LEN = 5;

  localparam logic [7:0] CH_AT  = 8'h40;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [2:0] {
    KIND_PONG     = 3'd0,
    KIND_TEXT     = 3'd1,
    KIND_OK       = 3'd2,
    KIND_UNKNOWN  = 3'd3,
    KIND_TOO_LONG = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_LONG
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  // Characters of the "PING" command, by position.
  function automatic logic [7:0] ping_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h4E;
      3'd3:    c = 8'h47;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // Characters of the "TEXT " prefix, by position.
  function automatic logic [7:0] text_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h54;
      3'd1:    c = 8'h45;
      3'd2:    c = 8'h58;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h20;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sfcp_line_ram.sv =====
`default_nettype none
module sfcp_line_ram (
  input  wire logic                          clk,
  input  wire sfcp_pkg::wr_req_t             wr,
  input  wire logic                          rd_en,
  input  wire logic [sfcp_pkg::ADDR_W-1:0]   rd_addr,
  output logic      [7:0]                    rd_data
);

  logic [7:0] mem [sfcp_pkg::LINE_MAX];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sync_framed_command_line_parser.sv =====
// A byte that causes no result is taken in idle and in_ready stays high.
// A line end walks the stored line, each stored byte through a line store read state
// and an evaluate state, and in_ready stays low until the line's last result is loaded.
// Text payload results come one per evaluate state; the walk stalls while out_valid
// is high and out_ready is low.
// Reset (rst_n, synchronous, active low) clears state, frame, overflow, count and out_valid only.
`default_nettype none
module sync_framed_command_line_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [2:0] out_kind,
  output logic      [7:0] out_text_byte,
  output logic            out_last
);

  localparam int CW = sfcp_pkg::CNT_W;
  localparam int AW = sfcp_pkg::ADDR_W;

  // Frame state. The line store itself lives in the RAM below.
  sfcp_pkg::state_t state_r, state_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             disc_r, disc_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;

  // Line walk state: position, prefix match flags, and whether the
  // header is done and payload bytes are being streamed.
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             ping_ok_r, ping_ok_nxt;
  logic             text_ok_r, text_ok_nxt;
  logic             stream_r, stream_nxt;

  // Output register; it lets the walk run ahead by one result.
  logic             out_valid_r, out_valid_nxt;
  sfcp_pkg::kind_t  out_kind_r, out_kind_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  sfcp_pkg::wr_req_t wr;
  logic              rd_en;
  logic [7:0]        rd_data;

  logic in_xfer;
  logic out_free;
  logic is_eol;
  logic content_end;
  logic p_match;
  logic t_match;

  // Writes happen only while idle and reads only during a line walk,
  // so the two ports never touch the same entry in overlapping cycles.
  sfcp_line_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign in_ready      = (state_r == sfcp_pkg::ST_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign is_eol        = (in_rx_byte == sfcp_pkg::CH_CR) || (in_rx_byte == sfcp_pkg::CH_LF);

  // The content ends at the fill count or at the first zero byte.
  assign content_end   = (idx_r == fill_r) || (rd_data == sfcp_pkg::CH_NUL);
  assign p_match       = ping_ok_r && (rd_data == sfcp_pkg::ping_char(idx_r[2:0]));
  assign t_match       = text_ok_r && (rd_data == sfcp_pkg::text_char(idx_r[2:0]));

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_text_byte = out_byte_r;
  assign out_last      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfcp_pkg::ST_IDLE;
      in_frame_r  <= 1'b0;
      disc_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      disc_r      <= disc_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ping_ok_r  <= ping_ok_nxt;
    text_ok_r  <= text_ok_nxt;
    stream_r   <= stream_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_frame_nxt  = in_frame_r;
    disc_nxt      = disc_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    ping_ok_nxt   = ping_ok_r;
    text_ok_nxt   = text_ok_r;
    stream_nxt    = stream_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    wr.en         = 1'b0;
    wr.addr       = fill_r[AW-1:0];
    wr.data       = in_rx_byte;
    rd_en         = 1'b0;

    case (state_r)
      sfcp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_rx_byte == sfcp_pkg::CH_AT) begin
            fill_nxt     = '0;
            disc_nxt     = 1'b0;
            in_frame_nxt = 1'b1;
          end else if (is_eol) begin
            in_frame_nxt = 1'b0;
            disc_nxt     = 1'b0;
            if (disc_r) begin
              fill_nxt  = '0;
              state_nxt = sfcp_pkg::ST_LONG;
            end else if (in_frame_r && (fill_r != '0)) begin
              // Keep the fill count for the walk; it is cleared at its end.
              idx_nxt     = '0;
              ping_ok_nxt = 1'b1;
              text_ok_nxt = 1'b1;
              stream_nxt  = 1'b0;
              state_nxt   = sfcp_pkg::ST_READ;
            end else begin
              fill_nxt = '0;
            end
          end else if (in_frame_r && !disc_r) begin
            if (fill_r >= CW'(sfcp_pkg::LINE_MAX - 1)) begin
              disc_nxt = 1'b1;
            end else begin
              wr.en    = 1'b1;
              fill_nxt = fill_r + CW'(1);
            end
          end
        end
      end

      sfcp_pkg::ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = sfcp_pkg::ST_EVAL;
      end

      sfcp_pkg::ST_EVAL: begin
        if (stream_r) begin
          // Payload: one text result per stored byte, then the ok.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = sfcp_pkg::CH_NUL;
            if (content_end) begin
              out_kind_nxt = sfcp_pkg::KIND_OK;
              out_last_nxt = 1'b1;
              fill_nxt     = '0;
              state_nxt    = sfcp_pkg::ST_IDLE;
            end else begin
              out_kind_nxt = sfcp_pkg::KIND_TEXT;
              out_byte_nxt = rd_data;
              out_last_nxt = 1'b0;
              idx_nxt      = idx_r + CW'(1);
              state_nxt    = sfcp_pkg::ST_READ;
            end
          end
        end else if (content_end) begin
          // Content ended inside the header: a pong only for exactly "PING".
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = sfcp_pkg::CH_NUL;
            out_last_nxt  = 1'b1;
            out_kind_nxt  = (ping_ok_r && (idx_r == CW'(sfcp_pkg::PING_LEN)))
                            ? sfcp_pkg::KIND_PONG : sfcp_pkg::KIND_UNKNOWN;
            fill_nxt      = '0;
            state_nxt     = sfcp_pkg::ST_IDLE;
          end
        end else if (idx_r < CW'(sfcp_pkg::PING_LEN)) begin
          if (p_match || t_match) begin
            ping_ok_nxt = p_match;
            text_ok_nxt = t_match;
            idx_nxt     = idx_r + CW'(1);
            state_nxt   = sfcp_pkg::ST_READ;
          end else if (out_free) begin
            // Neither prefix can still match.
            out_valid_nxt = 1'b1;
            out_kind_nxt  = sfcp_pkg::KIND_UNKNOWN;
            out_byte_nxt  = sfcp_pkg::CH_NUL;
            out_last_nxt  = 1'b1;
            fill_nxt      = '0;
            state_nxt     = sfcp_pkg::ST_IDLE;
          end
        end else begin
          // Fifth content byte: it must complete the "TEXT " prefix.
          if (t_match) begin
            stream_nxt = 1'b1;
            idx_nxt    = CW'(sfcp_pkg::TEXT_LEN);
            state_nxt  = sfcp_pkg::ST_READ;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = sfcp_pkg::KIND_UNKNOWN;
            out_byte_nxt  = sfcp_pkg::CH_NUL;
            out_last_nxt  = 1'b1;
            fill_nxt      = '0;
            state_nxt     = sfcp_pkg::ST_IDLE;
          end
        end
      end

      sfcp_pkg::ST_LONG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = sfcp_pkg::KIND_TOO_LONG;
          out_byte_nxt  = sfcp_pkg::CH_NUL;
          out_last_nxt  = 1'b1;
          state_nxt     = sfcp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sfcp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
